/* design/sapc_pkg.sv */
`timescale 1ns / 1ps
// Package for the set-associative position cache: payload structs, table entry
// layout, per-way evaluation flags, sequencer states and register codes.
// Has no dependencies; the way evaluator, the top level and the testbench import it.
package sapc_pkg;

	// Default geometry of the table.
	localparam int DEF_CLUSTER_BITS = 10;
	localparam int DEF_WAYS         = 3;

	// The tag is the top 16 bits of the position key.
	localparam int TAG_LSB = 48;
	localparam int TAG_W   = 16;

	// Generation bits within the age/bound byte, and the exact bound code.
	localparam logic [7:0] GEN_MASK  = 8'hFC;
	localparam logic [1:0] BND_EXACT = 2'd3;

	// Action codes of an input transfer.
	localparam logic ACT_PROBE = 1'b0;
	localparam logic ACT_STORE = 1'b1;

	// Configuration register indexes (byte address divided by four).
	localparam logic [1:0] REG_GEN   = 2'd0;
	localparam logic [1:0] REG_BAN_A = 2'd1;
	localparam logic [1:0] REG_BAN_B = 2'd2;

	localparam logic [5:0]  GEN_RESET = 6'd0;
	localparam logic [14:0] BAN_RESET = 15'd32767;

	// One input transfer.
	typedef struct packed {
		logic               action;
		logic [63:0]        position_key;
		logic signed [15:0] score;
		logic [1:0]         bound_kind;
		logic [7:0]         search_depth;
		logic [15:0]        best_move;
		logic signed [15:0] static_score;
	} req_t;

	// One result transfer.
	typedef struct packed {
		logic               hit;
		logic               stored;
		logic [15:0]        found_move;
		logic signed [15:0] found_score;
		logic signed [15:0] found_static;
		logic [7:0]         found_depth;
		logic [1:0]         found_bound;
	} rsp_t;

	// One table entry as held in the memory.
	typedef struct packed {
		logic [15:0] tag;
		logic [15:0] move;
		logic [15:0] score;
		logic [15:0] stat;
		logic [7:0]  age_bound;
		logic [7:0]  depth;
	} entry_t;

	// Flags that the way evaluator hands to the sequencer.
	typedef struct packed {
		logic matched;
		logic empty;
		logic cur;
		logic replace;
	} way_eval_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_WRITE,
		ST_RESP
	} state_t;

endpackage

/* design/sapc_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module sapc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/sapc_way_eval.sv */
`timescale 1ns / 1ps
// Shared way evaluator: compares one entry read from the table against the
// request tag and the current replacement victim. Depends on sapc_pkg.
module sapc_way_eval
	import sapc_pkg::*;
(
	input  entry_t           entry,
	input  logic [TAG_W-1:0] tag,
	input  logic [5:0]       generation,
	input  logic             victim_cur,
	input  logic [7:0]       victim_depth,
	output way_eval_t        result
);

	logic keep;
	logic shallower;

	// Tag, empty and generation checks on the entry.
	always_comb begin
		result.matched = (entry.tag == tag);
		result.empty   = (entry.tag == '0);
		result.cur     = ((entry.age_bound & GEN_MASK) == {generation, 2'b00});
		keep           = result.cur || (entry.age_bound[1:0] == BND_EXACT);
		shallower      = (entry.depth < victim_depth);
		// The entry displaces the victim when keep - victim_cur - shallower is negative.
		result.replace = keep ? (victim_cur && shallower) : (victim_cur || shallower);
	end

endmodule

/* design/set_assoc_position_cache_unit.sv */
`timescale 1ns / 1ps
// Top level of the set-associative position cache. Depends on sapc_pkg,
// sapc_ram and sapc_way_eval.

// A probe or store transfer is taken only while the unit is idle, and the unit
// stalls its input until the result has been loaded into the output register.
// The table lives in one memory with a single read port, so the ways of a
// cluster are read one after another: each way examined passes through a read
// state and then an evaluate state in the shared comparator, a write-back adds
// a write state, and the transfer is taken in the idle state and its result
// loaded in the result state. A probe hit ends the search and is written back;
// a miss reads every way and writes nothing. A store with a banned score goes
// straight to the result state. After reset a clearing pass writes zeros to
// all 2**(CLUSTER_BITS + way bits) memory rows, where the way bits are
// ceil(log2(WAYS)) but at least one, one row per cycle (4096 rows with the
// default geometry), before the first transfer is taken; configuration writes
// are accepted throughout.
module set_assoc_position_cache_unit
	import sapc_pkg::*;
#(
	parameter int CLUSTER_BITS = DEF_CLUSTER_BITS,
	parameter int WAYS         = DEF_WAYS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int ADDR_W   = CLUSTER_BITS + WAY_BITS;
	localparam int DEPTH    = 1 << ADDR_W;
	localparam logic [WAY_BITS-1:0] WAY_LAST = WAY_BITS'(WAYS - 1);

	state_t state_q, state_d;

	logic [5:0]  gen_q;
	logic [14:0] ban_a_q, ban_b_q;

	req_t                  req_q;
	logic                  banned_q;
	logic                  hit_q;
	logic [WAY_BITS-1:0]   way_q;
	logic [WAY_BITS-1:0]   victim_way_q;
	logic                  victim_cur_q;
	logic [7:0]            victim_depth_q;
	logic [15:0]           move_q;
	entry_t                entry_q;
	logic [ADDR_W-1:0]     clr_addr_q;
	rsp_t                  rsp_q;
	logic                  rsp_valid_q;

	logic                    ram_we;
	logic [ADDR_W-1:0]       ram_waddr;
	entry_t                  ram_wdata;
	logic [ADDR_W-1:0]       ram_raddr;
	entry_t                  ram_rdata;
	way_eval_t               ev;
	logic [CLUSTER_BITS-1:0] cluster;
	logic [TAG_W-1:0]        tag;
	logic [16:0]             mag;
	logic                    banned_now;
	logic                    req_take;
	logic                    rsp_free;
	logic                    cfg_wr;
	logic                    is_store;
	logic                    last_way;

	// APB register file; every access completes in its access cycle.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q   <= GEN_RESET;
			ban_a_q <= BAN_RESET;
			ban_b_q <= BAN_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_GEN:   gen_q   <= pwdata[5:0];
				REG_BAN_A: ban_a_q <= pwdata[14:0];
				REG_BAN_B: ban_b_q <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_GEN:   prdata = {26'd0, gen_q};
			REG_BAN_A: prdata = {17'd0, ban_a_q};
			REG_BAN_B: prdata = {17'd0, ban_b_q};
			default:   prdata = '0;
		endcase
	end

	// Absolute score of the incoming transfer and the banned-score check.
	always_comb begin
		mag        = req.score[15] ? (17'h10000 - {1'b0, req.score}) : {1'b0, req.score};
		banned_now = (req.action == ACT_STORE) &&
		             ((mag == {2'b00, ban_a_q}) || (mag == {2'b00, ban_b_q}));
	end

	assign req_stall = (state_q != ST_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign cluster  = req_q.position_key[CLUSTER_BITS-1:0];
	assign tag      = req_q.position_key[TAG_LSB +: TAG_W];
	assign is_store = (req_q.action == ACT_STORE);
	assign last_way = (way_q == WAY_LAST);

	// Table memory, one entry per row.
	sapc_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Shared comparator, used once per way read.
	sapc_way_eval u_eval (
		.entry       (ram_rdata),
		.tag         (tag),
		.generation  (gen_q),
		.victim_cur  (victim_cur_q),
		.victim_depth(victim_depth_q),
		.result      (ev)
	);

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_addr_q == '1) state_d = ST_IDLE;
			ST_IDLE: begin
				if (req_take) begin
					state_d = banned_now ? ST_RESP : ST_READ;
				end
			end
			ST_READ: state_d = ST_EVAL;
			ST_EVAL: begin
				if (is_store) begin
					state_d = (ev.matched || ev.empty || last_way) ? ST_WRITE : ST_READ;
				end else if (ev.matched) begin
					state_d = ST_WRITE;
				end else begin
					state_d = last_way ? ST_RESP : ST_READ;
				end
			end
			ST_WRITE: state_d = ST_RESP;
			ST_RESP: if (rsp_free) state_d = ST_IDLE;
			default: state_d = ST_CLEAR;
		endcase
	end

	// Memory controls from the sequencer state.
	always_comb begin
		ram_raddr = {cluster, way_q};
		ram_we    = 1'b0;
		ram_waddr = {cluster, victim_way_q};
		ram_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
			end
			ST_WRITE: begin
				ram_we = 1'b1;
				if (is_store) begin
					ram_wdata.tag       = tag;
					ram_wdata.move      = move_q;
					ram_wdata.score     = req_q.score;
					ram_wdata.stat      = req_q.static_score;
					ram_wdata.age_bound = {gen_q, req_q.bound_kind};
					ram_wdata.depth     = req_q.search_depth;
				end else begin
					// Probe hit: refresh the generation, keep the bound.
					ram_wdata           = entry_q;
					ram_wdata.age_bound = {gen_q, entry_q.age_bound[1:0]};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (state_q == ST_RESP && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Request capture and per-way bookkeeping.
	always_ff @(posedge clk) begin
		if (req_take) begin
			req_q    <= req;
			banned_q <= banned_now;
			hit_q    <= 1'b0;
			way_q    <= '0;
			move_q   <= req.best_move;
		end
		if (state_q == ST_EVAL) begin
			if (!is_store) begin
				if (ev.matched) begin
					hit_q        <= 1'b1;
					entry_q      <= ram_rdata;
					victim_way_q <= way_q;
				end
			end else if (ev.matched || ev.empty) begin
				victim_way_q <= way_q;
				if (req_q.best_move == '0) begin
					move_q <= ram_rdata.move;
				end
			end else if (way_q == '0 || ev.replace) begin
				victim_way_q   <= way_q;
				victim_cur_q   <= ev.cur;
				victim_depth_q <= ram_rdata.depth;
			end
			if (state_d == ST_READ) begin
				way_q <= way_q + 1'b1;
			end
		end
		if (state_q == ST_RESP && rsp_free) begin
			rsp_q.hit          <= hit_q;
			rsp_q.stored       <= is_store && !banned_q;
			rsp_q.found_move   <= hit_q ? entry_q.move : '0;
			rsp_q.found_score  <= hit_q ? entry_q.score : '0;
			rsp_q.found_static <= hit_q ? entry_q.stat : '0;
			rsp_q.found_depth  <= hit_q ? entry_q.depth : '0;
			rsp_q.found_bound  <= hit_q ? entry_q.age_bound[1:0] : '0;
		end
	end

`ifndef SYNTHESIS
	// A store with a banned score never reaches the write-back.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |-> !(is_store && banned_q))
		else $error("banned store reached write-back");

	// The way counter stays within the cluster while evaluating.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL) |-> (way_q <= WAY_LAST))
		else $error("way index beyond cluster");

	// Once the clearing pass is over it never restarts.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_CLEAR) |=> (state_q != ST_CLEAR))
		else $error("clearing pass restarted");

	// A result never reports both a hit and a store.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(rsp_q.hit && rsp_q.stored))
		else $error("result flags both hit and stored");

	// A probe write-back only follows a hit.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE && !is_store) |-> hit_q)
		else $error("probe write-back without hit");
`endif

endmodule

/* dv/set_assoc_position_cache_unit_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for set_assoc_position_cache_unit: directed probes and
// stores from a table, then random traffic on a few hot clusters across several
// register settings. Depends on sapc_pkg and the block's RTL.
module set_assoc_position_cache_unit_test;
	import sapc_pkg::*;

	localparam int CLUSTERS      = 1 << DEF_CLUSTER_BITS;
	localparam int ENTRY_COUNT   = CLUSTERS * DEF_WAYS;
	localparam int ITEMS_PER_RUN = 179;
	localparam int PHASES        = 8;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int HOLD_CYCLES   = 250;
	localparam int IDLE_PERCENT  = 22;
	// Register index with no register behind it.
	localparam logic [1:0] REG_NONE = 2'd3;

	typedef struct {
		req_t item;
		bit   fixed;
		rsp_t result;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Shadow copy of the table and the registers.
	logic [15:0] tbl_tag [ENTRY_COUNT];
	logic [15:0] tbl_move [ENTRY_COUNT];
	logic [15:0] tbl_score [ENTRY_COUNT];
	logic [15:0] tbl_stat [ENTRY_COUNT];
	logic [7:0]  tbl_age_bound [ENTRY_COUNT];
	logic [7:0]  tbl_depth [ENTRY_COUNT];
	logic [5:0]  cur_gen = GEN_RESET;
	logic [14:0] ban_a = BAN_RESET;
	logic [14:0] ban_b = BAN_RESET;

	rsp_t        expected_results[$];
	row_t        directed_rows[$];
	logic [9:0]  hot_clusters [4];
	logic [15:0] hot_tags [8];
	int          mismatch_count = 0;
	int          cycle_count = 0;
	int          hold_left = 0;
	bit          quiet = 1'b0;

	set_assoc_position_cache_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// An entry is current when its generation bits equal the search generation.
	function automatic bit is_current(int e);
		return (tbl_age_bound[e] & GEN_MASK) == {cur_gen, 2'b00};
	endfunction

	// Applies one probe or store to the shadow table and returns its result.
	function automatic rsp_t cache_access(req_t r);
		rsp_t        res;
		logic [15:0] tag;
		logic [15:0] mv;
		logic [16:0] mag;
		int          base, victim, e, i;
		int          keep, older, shallower;
		bit          done;
		res = '0;
		done = 1'b0;
		tag = r.position_key[TAG_LSB +: TAG_W];
		base = r.position_key[DEF_CLUSTER_BITS-1:0] * DEF_WAYS;
		if (r.action == ACT_PROBE) begin
			for (i = 0; i < DEF_WAYS; i++) begin
				e = base + i;
				if (!done && tbl_tag[e] == tag) begin
					done = 1'b1;
					tbl_age_bound[e] = {cur_gen, tbl_age_bound[e][1:0]};
					res.hit = 1'b1;
					res.found_move = tbl_move[e];
					res.found_score = tbl_score[e];
					res.found_static = tbl_stat[e];
					res.found_depth = tbl_depth[e];
					res.found_bound = tbl_age_bound[e][1:0];
				end
			end
			return res;
		end
		// Stores whose absolute score is banned are dropped.
		mag = r.score[15] ? 17'h10000 - {1'b0, r.score} : {1'b0, r.score};
		if (mag == {2'b00, ban_a} || mag == {2'b00, ban_b})
			return res;
		victim = base;
		mv = r.best_move;
		for (i = 0; i < DEF_WAYS; i++) begin
			e = base + i;
			if (!done) begin
				if (tbl_tag[e] == 16'h0 || tbl_tag[e] == tag) begin
					if (mv == 16'h0)
						mv = tbl_move[e];
					victim = e;
					done = 1'b1;
				end else begin
					keep = (is_current(e) || tbl_age_bound[e][1:0] == BND_EXACT) ? 1 : 0;
					older = is_current(victim) ? 1 : 0;
					shallower = (tbl_depth[e] < tbl_depth[victim]) ? 1 : 0;
					if (keep - older - shallower < 0)
						victim = e;
				end
			end
		end
		tbl_tag[victim] = tag;
		tbl_move[victim] = mv;
		tbl_score[victim] = r.score;
		tbl_stat[victim] = r.static_score;
		tbl_age_bound[victim] = {cur_gen, r.bound_kind};
		tbl_depth[victim] = r.search_depth;
		res.stored = 1'b1;
		return res;
	endfunction

	function automatic req_t mk_req(logic act, logic [63:0] key, logic [15:0] sc,
			logic [1:0] bnd, logic [7:0] dep, logic [15:0] mv, logic [15:0] st);
		req_t r;
		r.action = act;
		r.position_key = key;
		r.score = sc;
		r.bound_kind = bnd;
		r.search_depth = dep;
		r.best_move = mv;
		r.static_score = st;
		return r;
	endfunction

	function automatic rsp_t mk_rsp(logic h, logic s, logic [15:0] mv, logic [15:0] sc,
			logic [15:0] st, logic [7:0] dep, logic [1:0] bnd);
		rsp_t x;
		x.hit = h;
		x.stored = s;
		x.found_move = mv;
		x.found_score = sc;
		x.found_static = st;
		x.found_depth = dep;
		x.found_bound = bnd;
		return x;
	endfunction

	task automatic add_row(req_t item, bit fixed, rsp_t result);
		row_t row;
		row.item = item;
		row.fixed = fixed;
		row.result = result;
		directed_rows.push_back(row);
	endtask

	// Random traffic mostly lands on a few hot clusters with a small tag pool,
	// so that hits, way reuse and eviction all happen often.
	function automatic req_t random_item();
		req_t r;
		r.action = 1'($urandom_range(1));
		r.position_key = {$urandom, $urandom};
		if ($urandom_range(99) < 85) begin
			r.position_key[DEF_CLUSTER_BITS-1:0] = hot_clusters[$urandom_range(3)];
			r.position_key[TAG_LSB +: TAG_W] = hot_tags[$urandom_range(7)];
		end
		r.score = 16'($urandom);
		if ($urandom_range(3) == 0) begin
			case ($urandom_range(5))
				0: r.score = {1'b0, ban_a};
				1: r.score = 16'h0 - {1'b0, ban_a};
				2: r.score = {1'b0, ban_b};
				3: r.score = 16'h0 - {1'b0, ban_b};
				4: r.score = 16'h8000;
				default: r.score = 16'h7FFF;
			endcase
		end
		r.bound_kind = 2'($urandom_range(3));
		r.search_depth = ($urandom_range(2) == 0) ? 8'($urandom_range(3))
		                                          : 8'($urandom_range(255));
		r.best_move = ($urandom_range(3) == 0) ? 16'h0 : 16'($urandom_range(16'hFFFF));
		r.static_score = 16'($urandom);
		return r;
	endfunction

	// Offers one transfer, holding it until taken, and records what it should return.
	task automatic send_item(req_t item, bit fixed, rsp_t result);
		rsp_t predicted;
		@(negedge clk);
		if (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(negedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		predicted = cache_access(item);
		expected_results.push_back(fixed ? result : predicted);
	endtask

	// Stops offering and waits for every outstanding result.
	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_GEN:   cur_gen = val[5:0];
			REG_BAN_A: ban_a = val[14:0];
			REG_BAN_B: ban_b = val[14:0];
			default:   ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic reg_check(logic [1:0] idx);
		logic [31:0] want;
		case (idx)
			REG_GEN:   want = {26'b0, cur_gen};
			REG_BAN_A: want = {17'b0, ban_a};
			default:   want = {17'b0, ban_b};
		endcase
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) begin
			$display("%0t: register %0d expected %h actual %h", $time, idx, want, prdata);
			mismatch_count++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic cmp_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Receiver: random stalls, a quiet stretch, and a long hold-off when asked.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else if (quiet)
				rsp_stall <= 1'b0;
			else
				rsp_stall <= ($urandom_range(99) < IDLE_PERCENT);
		end
	end

	// Each result transfer is compared with the oldest expectation.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result with nothing expected, actual %h", $time, rsp);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				cmp_field("hit", 16'(want.hit), 16'(rsp.hit));
				cmp_field("stored", 16'(want.stored), 16'(rsp.stored));
				cmp_field("found_move", want.found_move, rsp.found_move);
				cmp_field("found_score", want.found_score, rsp.found_score);
				cmp_field("found_static", want.found_static, rsp.found_static);
				cmp_field("found_depth", 16'(want.found_depth), 16'(rsp.found_depth));
				cmp_field("found_bound", 16'(want.found_bound), 16'(rsp.found_bound));
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		logic [5:0]  gen_plan [PHASES];
		logic [14:0] ban_a_plan [PHASES];
		logic [14:0] ban_b_plan [PHASES];
		int          e, k, phase;
		rsp_t        none;
		gen_plan = '{6'd1, 6'd63, 6'd63, 6'd0, 6'd5, 6'd2, 6'd2, 6'd62};
		ban_a_plan = '{15'd0, 15'd32767, 15'd100, 15'd1, 15'd32766, 15'd32767, 15'd7, 15'd0};
		ban_b_plan = '{15'd32767, 15'd0, 15'd100, 15'd32767, 15'd1, 15'd0, 15'd9, 15'd0};
		gen_plan[4] = 6'($urandom_range(63));
		ban_a_plan[6] = 15'($urandom_range(32767));
		ban_b_plan[6] = 15'($urandom_range(32767));
		for (e = 0; e < ENTRY_COUNT; e++) begin
			tbl_tag[e] = '0;
			tbl_move[e] = '0;
			tbl_score[e] = '0;
			tbl_stat[e] = '0;
			tbl_age_bound[e] = '0;
			tbl_depth[e] = '0;
		end
		hot_clusters = '{10'd0, 10'd1023, 10'd0, 10'd0};
		hot_clusters[2] = 10'($urandom_range(1022, 1));
		hot_clusters[3] = 10'($urandom_range(1022, 1));
		hot_tags[0] = 16'h0;
		hot_tags[1] = 16'hFFFF;
		for (k = 2; k < 8; k++)
			hot_tags[k] = 16'($urandom_range(16'hFFFE, 1));
		none = mk_rsp(0, 0, 0, 0, 0, 0, 0);

		// Directed rows, run with the reset settings. Empty table: a miss, then a
		// zero tag that matches an empty way.
		add_row(mk_req(ACT_PROBE, 64'h1234_0000_0000_0005, 0, 0, 0, 0, 0), 1, none);
		add_row(mk_req(ACT_PROBE, 64'h0000_0000_0000_0007, 0, 0, 0, 0, 0), 1,
			mk_rsp(1, 0, 0, 0, 0, 0, 0));
		// Banned magnitude of either sign is dropped; the most negative score is not.
		add_row(mk_req(ACT_STORE, '1, 16'h7FFF, 3, 255, 16'hFFFF, 16'h8000), 1, none);
		add_row(mk_req(ACT_STORE, '1, 16'h8001, 3, 255, 16'hFFFF, 16'h8000), 1, none);
		add_row(mk_req(ACT_STORE, '1, 16'h8000, 3, 255, 16'hFFFF, 16'h8000), 1,
			mk_rsp(0, 1, 0, 0, 0, 0, 0));
		add_row(mk_req(ACT_PROBE, '1, 0, 0, 0, 0, 0), 1,
			mk_rsp(1, 0, 16'hFFFF, 16'h8000, 16'h8000, 255, 3));
		// A zero move keeps the move already in the way.
		add_row(mk_req(ACT_STORE, '1, 16'd100, 1, 0, 16'h0, 16'h7FFF), 1,
			mk_rsp(0, 1, 0, 0, 0, 0, 0));
		add_row(mk_req(ACT_PROBE, '1, 0, 0, 0, 0, 0), 1,
			mk_rsp(1, 0, 16'hFFFF, 16'd100, 16'h7FFF, 0, 1));
		// Store and probe with a zero tag.
		add_row(mk_req(ACT_STORE, 64'h2, 16'd5, 2, 7, 16'h0101, 16'hFFFF), 0, none);
		add_row(mk_req(ACT_PROBE, 64'h2, 0, 0, 0, 0, 0), 0, none);
		// Fill one cluster, then force an eviction and probe every tag.
		add_row(mk_req(ACT_STORE, 64'h1111_0000_0000_0003, 16'd1, 0, 10, 16'h11, 16'd1), 0, none);
		add_row(mk_req(ACT_STORE, 64'h2222_0000_0000_0003, 16'd2, 3, 5, 16'h22, 16'd2), 0, none);
		add_row(mk_req(ACT_STORE, 64'h3333_0000_0000_0003, 16'd3, 0, 20, 16'h33, 16'd3), 0, none);
		add_row(mk_req(ACT_STORE, 64'h4444_0000_0000_0003, 16'd4, 1, 1, 16'h44, 16'd4), 0, none);
		add_row(mk_req(ACT_PROBE, 64'h1111_0000_0000_0003, 0, 0, 0, 0, 0), 0, none);
		add_row(mk_req(ACT_PROBE, 64'h2222_0000_0000_0003, 0, 0, 0, 0, 0), 0, none);
		add_row(mk_req(ACT_PROBE, 64'h3333_0000_0000_0003, 0, 0, 0, 0, 0), 0, none);
		add_row(mk_req(ACT_PROBE, 64'h4444_0000_0000_0003, 0, 0, 0, 0, 0), 0, none);
		add_row(mk_req(ACT_PROBE, 64'h8000_0000_0000_0000, 0, 0, 0, 0, 0), 0, none);

		// Reset, then check that the reset values read back and that a write to an
		// unused address changes nothing.
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		reg_write(REG_NONE, 32'hFFFF_FFFF);
		reg_check(REG_GEN);
		reg_check(REG_BAN_A);
		reg_check(REG_BAN_B);

		for (k = 0; k < directed_rows.size(); k++)
			send_item(directed_rows[k].item, directed_rows[k].fixed, directed_rows[k].result);

		// Random phases, each under its own register setting.
		for (phase = 0; phase < PHASES; phase++) begin
			drain();
			reg_write(REG_GEN, {26'b0, gen_plan[phase]});
			reg_write(REG_BAN_A, {17'b0, ban_a_plan[phase]});
			reg_write(REG_BAN_B, {17'b0, ban_b_plan[phase]});
			reg_check(REG_GEN);
			reg_check(REG_BAN_A);
			reg_check(REG_BAN_B);
			// The receiver holds off long enough for the block to back up.
			if (phase == 2)
				hold_left = HOLD_CYCLES;
			quiet = (phase == 4);
			for (k = 0; k < ITEMS_PER_RUN; k++)
				send_item(random_item(), 0, none);
		end
		quiet = 1'b0;

		drain();
		repeat (12) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
